/* hdl/differential_vector_clock_defines.svh */
// assertion macros shared by the differential vector clock rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef DIFFERENTIAL_VECTOR_CLOCK_DEFINES_SVH
`define DIFFERENTIAL_VECTOR_CLOCK_DEFINES_SVH

// same-cycle implication, checked out of reset only
`define DVC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset only
`define DVC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/dvc_pkg.sv */
// shared types, codes and constants of the differential vector clock
// no dependencies
`timescale 1ns / 1ps

package dvc_pkg;

	localparam int MAX_PROCESSES = 16;
	localparam int IDX_W         = 4;
	localparam int TBL_DEPTH     = 1 << IDX_W;
	localparam int CNT_W         = 5;
	localparam int VAL_W         = 32;
	localparam int CFG_W         = 5;
	localparam logic [VAL_W-1:0] CLOCK_MAX = {VAL_W{1'b1}};

	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 4;

	// configuration register indexes
	localparam logic REG_OWN_ID   = 1'b0;
	localparam logic REG_NUM_PROC = 1'b1;

	typedef enum logic [1:0] {
		KIND_INTERNAL   = 2'd0,
		KIND_SEND       = 2'd1,
		KIND_RECV_START = 2'd2,
		KIND_RECV_TUPLE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_BUMP,
		OP_SEND,
		OP_TUPLE
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXEC,
		BK_SCAN,
		BK_FLUSH
	} bk_state_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] me;
		logic [CNT_W-1:0] n;
		logic [IDX_W-1:0] peer;
		logic [IDX_W-1:0] tidx;
		logic [VAL_W-1:0] tval;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic             last;
	} res_t;

	typedef struct packed {
		logic full;
		logic room2;
	} res_status_t;

endpackage

/* hdl/dvc_front.sv */
// front end: configuration registers, range checks and command decode
// depends on dvc_pkg
`timescale 1ns / 1ps

module dvc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [dvc_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       push,
	input  logic [1:0]                 kind,
	input  logic [dvc_pkg::IDX_W-1:0]  peer_id,
	input  logic [dvc_pkg::IDX_W-1:0]  tuple_index,
	input  logic [dvc_pkg::VAL_W-1:0]  tuple_value,
	input  logic                       q_full,
	output logic                       q_push,
	output dvc_pkg::cmd_t              q_cmd
);

	logic [dvc_pkg::IDX_W-1:0] own_id_q;
	logic [dvc_pkg::CNT_W-1:0] num_proc_q;
	logic [dvc_pkg::CNT_W-1:0] n;
	logic                      ignore;
	dvc_pkg::kind_t            kind_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q   <= '0;
			num_proc_q <= dvc_pkg::CNT_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				dvc_pkg::REG_OWN_ID:   own_id_q   <= cfg_data[dvc_pkg::IDX_W-1:0];
				dvc_pkg::REG_NUM_PROC: num_proc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// entries in use, at least one and clamped to the table size
	always_comb begin
		if (num_proc_q == '0)
			n = dvc_pkg::CNT_W'(1);
		else if (num_proc_q > dvc_pkg::CNT_W'(dvc_pkg::MAX_PROCESSES))
			n = dvc_pkg::CNT_W'(dvc_pkg::MAX_PROCESSES);
		else
			n = num_proc_q;
		if (n > dvc_pkg::CNT_W'(dvc_pkg::TBL_DEPTH))
			n = dvc_pkg::CNT_W'(dvc_pkg::TBL_DEPTH);
	end

	assign kind_c = dvc_pkg::kind_t'(kind);

	always_comb begin
		ignore = ({1'b0, own_id_q} >= n);
		q_cmd.op = dvc_pkg::OP_BUMP;
		case (kind_c)
			dvc_pkg::KIND_SEND: begin
				q_cmd.op = dvc_pkg::OP_SEND;
				if ({1'b0, peer_id} >= n)
					ignore = 1'b1;
			end
			dvc_pkg::KIND_RECV_TUPLE: begin
				q_cmd.op = dvc_pkg::OP_TUPLE;
				if ({1'b0, tuple_index} >= n)
					ignore = 1'b1;
			end
			default: q_cmd.op = dvc_pkg::OP_BUMP;
		endcase
		q_cmd.me   = own_id_q;
		q_cmd.n    = n;
		q_cmd.peer = peer_id;
		q_cmd.tidx = tuple_index;
		q_cmd.tval = tuple_value;
	end

	// out-of-range items are dropped without a transfer to the back end
	assign q_push = push && !q_full && !ignore;

endmodule

/* hdl/dvc_cmd_queue.sv */
// short command queue between front and back end
// depends on dvc_pkg
`timescale 1ns / 1ps

module dvc_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  dvc_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output dvc_pkg::cmd_t rd_cmd
);

	localparam int PTR_W = $clog2(dvc_pkg::CMDQ_DEPTH);
	localparam int CNT_QW = $clog2(dvc_pkg::CMDQ_DEPTH + 1);

	dvc_pkg::cmd_t     slot_q [dvc_pkg::CMDQ_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full     = (count_q == CNT_QW'(dvc_pkg::CMDQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CNT_QW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CNT_QW'(1);
		end
	end

endmodule

/* hdl/dvc_back.sv */
// back end: clock tables and the sequencer that runs bump, tuple and send
// depends on dvc_pkg and differential_vector_clock_defines.svh
`timescale 1ns / 1ps
`include "differential_vector_clock_defines.svh"

module dvc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  dvc_pkg::cmd_t        cmd_head,
	output logic                 cmd_pop,
	input  dvc_pkg::res_status_t res_st,
	output logic                 res_push,
	output dvc_pkg::res_t        res_data
);

	localparam int IW = dvc_pkg::IDX_W;
	localparam int VW = dvc_pkg::VAL_W;
	localparam int CW = dvc_pkg::CNT_W;
	localparam int DP = dvc_pkg::TBL_DEPTH;

	logic [VW-1:0] vc_mem [DP];
	logic [VW-1:0] lu_mem [DP];
	logic [VW-1:0] ls_mem [DP];
	logic [DP-1:0] vc_vld_q;
	logic [DP-1:0] lu_vld_q;
	logic [DP-1:0] ls_vld_q;

	dvc_pkg::bk_state_t state_q, state_d;
	dvc_pkg::cmd_t      cmd_q;
	logic [CW-1:0]      scan_k_q;
	logic [VW-1:0]      stamp_q;
	logic [VW-1:0]      own_q;
	logic               held_v_q;
	logic [IW-1:0]      held_idx_q;
	logic [VW-1:0]      held_val_q;
	logic               rd_v_s1;
	logic [IW-1:0]      rd_idx_s1;

	logic [VW-1:0] vc_a_s1, vc_b_s1, lu_s1, ls_s1;
	logic [IW-1:0] addr_a, addr_b, addr_lu, addr_ls;

	logic          vc_we, lu_we, ls_we;
	logic [IW-1:0] vc_waddr, lu_waddr;
	logic [VW-1:0] vc_wdata, lu_wdata;
	logic [VW-1:0] inc;
	logic          raise;
	logic          issue;
	logic          hit;
	logic          flush_done;

	// read addresses: queue head when idle, scan index while scanning
	always_comb begin
		case (state_q)
			dvc_pkg::BK_IDLE: begin
				addr_a  = cmd_head.me;
				addr_b  = cmd_head.tidx;
				addr_lu = cmd_head.me;
				addr_ls = cmd_head.peer;
			end
			dvc_pkg::BK_SCAN: begin
				addr_a  = scan_k_q[IW-1:0];
				addr_b  = cmd_q.tidx;
				addr_lu = scan_k_q[IW-1:0];
				addr_ls = cmd_q.peer;
			end
			default: begin
				addr_a  = cmd_q.me;
				addr_b  = cmd_q.tidx;
				addr_lu = cmd_q.me;
				addr_ls = cmd_q.peer;
			end
		endcase
	end

	// tables, unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (vc_we)
			vc_mem[vc_waddr] <= vc_wdata;
		if (lu_we)
			lu_mem[lu_waddr] <= lu_wdata;
		if (ls_we)
			ls_mem[cmd_q.peer] <= own_q;
		vc_a_s1 <= vc_vld_q[addr_a]  ? vc_mem[addr_a]  : '0;
		vc_b_s1 <= vc_vld_q[addr_b]  ? vc_mem[addr_b]  : '0;
		lu_s1   <= lu_vld_q[addr_lu] ? lu_mem[addr_lu] : '0;
		ls_s1   <= ls_vld_q[addr_ls] ? ls_mem[addr_ls] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_vld_q <= '0;
			lu_vld_q <= '0;
			ls_vld_q <= '0;
		end else begin
			if (vc_we)
				vc_vld_q[vc_waddr] <= 1'b1;
			if (lu_we)
				lu_vld_q[lu_waddr] <= 1'b1;
			if (ls_we)
				ls_vld_q[cmd_q.peer] <= 1'b1;
		end
	end

	assign inc   = (vc_a_s1 == dvc_pkg::CLOCK_MAX) ? vc_a_s1 : vc_a_s1 + VW'(1);
	assign raise = (vc_b_s1 < cmd_q.tval);
	assign hit   = rd_v_s1 && (lu_s1 > stamp_q);
	assign flush_done = !held_v_q || !res_st.full;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dvc_pkg::BK_IDLE:
				if (cmd_valid)
					state_d = dvc_pkg::BK_EXEC;
			dvc_pkg::BK_EXEC:
				if (cmd_q.op == dvc_pkg::OP_SEND)
					state_d = dvc_pkg::BK_SCAN;
				else if (!res_st.full)
					state_d = dvc_pkg::BK_IDLE;
			dvc_pkg::BK_SCAN:
				if (scan_k_q == cmd_q.n && !rd_v_s1)
					state_d = dvc_pkg::BK_FLUSH;
			dvc_pkg::BK_FLUSH:
				if (flush_done)
					state_d = dvc_pkg::BK_IDLE;
			default: state_d = dvc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		vc_we    = 1'b0;
		lu_we    = 1'b0;
		ls_we    = 1'b0;
		vc_waddr = cmd_q.me;
		lu_waddr = cmd_q.me;
		vc_wdata = inc;
		lu_wdata = inc;
		res_push = 1'b0;
		res_data = '{index: held_idx_q, value: held_val_q, last: 1'b0};
		issue    = 1'b0;
		case (state_q)
			dvc_pkg::BK_IDLE:
				cmd_pop = cmd_valid;
			dvc_pkg::BK_EXEC: begin
				case (cmd_q.op)
					dvc_pkg::OP_SEND: begin
						vc_we = 1'b1;
						lu_we = 1'b1;
					end
					dvc_pkg::OP_TUPLE: begin
						vc_waddr = cmd_q.tidx;
						lu_waddr = cmd_q.tidx;
						vc_wdata = cmd_q.tval;
						// a tuple naming the own entry stamps with the raised value
						lu_wdata = (cmd_q.tidx == cmd_q.me) ? cmd_q.tval : vc_a_s1;
						res_data = '{index: cmd_q.tidx,
							value: raise ? cmd_q.tval : vc_b_s1, last: 1'b1};
						if (!res_st.full) begin
							res_push = 1'b1;
							vc_we    = raise;
							lu_we    = raise;
						end
					end
					default: begin
						res_data = '{index: cmd_q.me, value: inc, last: 1'b1};
						if (!res_st.full) begin
							res_push = 1'b1;
							vc_we    = 1'b1;
							lu_we    = 1'b1;
						end
					end
				endcase
			end
			dvc_pkg::BK_SCAN: begin
				// one read in flight at most, so two free slots cover it
				issue    = (scan_k_q < cmd_q.n) && res_st.room2;
				res_push = hit && held_v_q;
			end
			dvc_pkg::BK_FLUSH: begin
				res_data.last = 1'b1;
				res_push = held_v_q && !res_st.full;
				ls_we    = flush_done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dvc_pkg::BK_IDLE;
			held_v_q <= 1'b0;
			rd_v_s1  <= 1'b0;
			scan_k_q <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (state_q == dvc_pkg::BK_EXEC) begin
				scan_k_q <= '0;
				held_v_q <= 1'b0;
			end else if (state_q == dvc_pkg::BK_SCAN) begin
				if (issue)
					scan_k_q <= scan_k_q + CW'(1);
				if (hit)
					held_v_q <= 1'b1;
			end else if (state_q == dvc_pkg::BK_FLUSH && flush_done) begin
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cmd_q <= cmd_head;
		if (state_q == dvc_pkg::BK_EXEC) begin
			stamp_q <= ls_s1;
			own_q   <= inc;
		end
		rd_idx_s1 <= scan_k_q[IW-1:0];
		if (state_q == dvc_pkg::BK_SCAN && hit) begin
			held_idx_q <= rd_idx_s1;
			held_val_q <= vc_a_s1;
		end
	end

	`DVC_ASSERT_IMPL(a_push_room, res_push, !res_st.full, "result transfer into a full queue")
	`DVC_ASSERT_IMPL(a_held_scope, held_v_q,
		state_q == dvc_pkg::BK_SCAN || state_q == dvc_pkg::BK_FLUSH, "held result outside a send")
	`DVC_ASSERT_NEXT(a_issue_eval, issue, rd_v_s1 && state_q == dvc_pkg::BK_SCAN,
		"scan read lost before evaluation")
	`DVC_ASSERT_IMPL(a_scan_bound, state_q == dvc_pkg::BK_SCAN, scan_k_q <= cmd_q.n,
		"scan index past entries in use")

endmodule

/* hdl/dvc_res_queue.sv */
// result queue feeding the output side
// depends on dvc_pkg
`timescale 1ns / 1ps

module dvc_res_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  dvc_pkg::res_t        wr_res,
	output dvc_pkg::res_status_t status,
	input  logic                 rd_en,
	output logic                 empty,
	output dvc_pkg::res_t        rd_res
);

	localparam int PTR_W  = $clog2(dvc_pkg::RESQ_DEPTH);
	localparam int CNT_QW = $clog2(dvc_pkg::RESQ_DEPTH + 1);

	dvc_pkg::res_t     slot_q [dvc_pkg::RESQ_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign status.full  = (count_q == CNT_QW'(dvc_pkg::RESQ_DEPTH));
	assign status.room2 = (count_q <= CNT_QW'(dvc_pkg::RESQ_DEPTH - 2));
	assign empty  = (count_q == '0);
	assign rd_res = slot_q[rd_ptr_q];
	assign do_wr  = wr_en && !status.full;
	assign do_rd  = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wr_ptr_q] <= wr_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CNT_QW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CNT_QW'(1);
		end
	end

endmodule

/* hdl/differential_vector_clock.sv */
// Internal and receive-start items: one result each.
// Receive tuples: one result.
// Sends: a scan of the tables, one entry per cycle while the result queue has room for two.
// Front end accepts into a 2-deep command queue; results leave from a 4-deep queue.
// Reset clears all three tables at once through per-entry valid bits, no sweep.
// depends on dvc_pkg and the dvc_ submodules
`timescale 1ns / 1ps

module differential_vector_clock (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [dvc_pkg::CFG_W-1:0] cfg_data,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                kind,
	input  logic [dvc_pkg::IDX_W-1:0] peer_id,
	input  logic [dvc_pkg::IDX_W-1:0] tuple_index,
	input  logic [dvc_pkg::VAL_W-1:0] tuple_value,
	output logic                      empty,
	input  logic                      pop,
	output logic [dvc_pkg::IDX_W-1:0] entry_index,
	output logic [dvc_pkg::VAL_W-1:0] entry_value,
	output logic                      last_of_run
);

	logic                 q_push;
	dvc_pkg::cmd_t        q_cmd;
	logic                 cmd_valid;
	dvc_pkg::cmd_t        cmd_head;
	logic                 cmd_pop;
	dvc_pkg::res_status_t res_st;
	logic                 res_push;
	dvc_pkg::res_t        res_data;
	dvc_pkg::res_t        res_head;

	dvc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.kind        (kind),
		.peer_id     (peer_id),
		.tuple_index (tuple_index),
		.tuple_value (tuple_value),
		.q_full      (full),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	dvc_cmd_queue u_cmd_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_cmd   (q_cmd),
		.full     (full),
		.rd_en    (cmd_pop),
		.rd_valid (cmd_valid),
		.rd_cmd   (cmd_head)
	);

	dvc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_st    (res_st),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	dvc_res_queue u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_res (res_data),
		.status (res_st),
		.rd_en  (pop),
		.empty  (empty),
		.rd_res (res_head)
	);

	assign entry_index = res_head.index;
	assign entry_value = res_head.value;
	assign last_of_run = res_head.last;

endmodule

/* bench/tb_top.sv */
// self-checking bench for differential_vector_clock: a built-in predictor of the
// vector clock tables, directed and random event streams, random stalls on both sides
// depends on dvc_pkg and the differential_vector_clock rtl
`timescale 1ns / 1ps

module tb_top;
	import dvc_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 64;

	// predicts the entries each event reports and checks them in order
	class vclock_tracker;
		logic [VAL_W-1:0] clock_vec [TBL_DEPTH];
		logic [VAL_W-1:0] upd_stamp [TBL_DEPTH];
		logic [VAL_W-1:0] sent_stamp [TBL_DEPTH];
		logic [IDX_W-1:0] own;
		logic [CNT_W-1:0] nproc;
		res_t             pending [$];
		int               mismatches;

		function new();
			foreach (clock_vec[i]) begin
				clock_vec[i]  = '0;
				upd_stamp[i]  = '0;
				sent_stamp[i] = '0;
			end
			own        = '0;
			nproc      = CNT_W'(16);
			mismatches = 0;
		endfunction

		function void set_reg(logic index, logic [CFG_W-1:0] data);
			if (index == REG_OWN_ID) own = data[IDX_W-1:0];
			else nproc = data;
		endfunction

		function int unsigned in_use();
			int unsigned n;
			n = nproc;
			if (n < 1) n = 1;
			if (n > MAX_PROCESSES) n = MAX_PROCESSES;
			if (n > TBL_DEPTH) n = TBL_DEPTH;
			return n;
		endfunction

		function void expect_entry(int unsigned index, logic last);
			res_t r;
			r.index = index[IDX_W-1:0];
			r.value = clock_vec[index];
			r.last  = last;
			pending = {pending, r};
		endfunction

		function void bump_own();
			if (clock_vec[own] != CLOCK_MAX) clock_vec[own] = clock_vec[own] + 1;
			upd_stamp[own] = clock_vec[own];
		endfunction

		function void note_event(kind_t k, logic [IDX_W-1:0] peer, logic [IDX_W-1:0] tidx,
				logic [VAL_W-1:0] tval);
			int unsigned      n;
			int unsigned      first;
			logic [VAL_W-1:0] stamp;
			n = in_use();
			if (own >= n) return;
			case (k)
				KIND_INTERNAL, KIND_RECV_START: begin
					bump_own();
					expect_entry(own, 1'b1);
				end
				KIND_RECV_TUPLE: begin
					if (tidx >= n) return;
					if (clock_vec[tidx] < tval) begin
						clock_vec[tidx] = tval;
						upd_stamp[tidx] = clock_vec[own];
					end
					expect_entry(tidx, 1'b1);
				end
				KIND_SEND: begin
					if (peer >= n) return;
					bump_own();
					stamp = sent_stamp[peer];
					first = pending.size();
					for (int unsigned i = 0; i < n; i++)
						if (upd_stamp[i] > stamp) expect_entry(i, 1'b0);
					// only the final entry of the run carries the marker
					if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
					sent_stamp[peer] = clock_vec[own];
				end
				default: ;
			endcase
		endfunction

		function void check_entry(logic [IDX_W-1:0] index, logic [VAL_W-1:0] value, logic last);
			res_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected entry: index %0d value %h last %0b", index, value, last);
				return;
			end
			want = pending.pop_front();
			if (want.index !== index || want.value !== value || want.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want idx %0d val %h last %0b, got idx %0d val %h last %0b",
						want.index, want.value, want.last, index, value, last);
			end
		endfunction

		function int tally();
			mismatches += pending.size();
			return mismatches;
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             push;
	logic             full;
	logic [1:0]       kind;
	logic [IDX_W-1:0] peer_id;
	logic [IDX_W-1:0] tuple_index;
	logic [VAL_W-1:0] tuple_value;
	logic             empty;
	logic             pop;
	logic [IDX_W-1:0] entry_index;
	logic [VAL_W-1:0] entry_value;
	logic             last_of_run;

	vclock_tracker tracker = new();
	int            stall_cycles = 0;
	int            hold_requests = 0;
	bit            idling = 1'b1;

	differential_vector_clock i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.peer_id     (peer_id),
		.tuple_index (tuple_index),
		.tuple_value (tuple_value),
		.empty       (empty),
		.pop         (pop),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.last_of_run (last_of_run)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// cycles without any transfer on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
	end

	initial begin : watchdog
		do @(posedge clk); while (stall_cycles < STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// result side: checks each transfer, stalls in bursts, or for a long stretch on request
	initial begin : result_side
		int gap;
		int hold_left;
		int holds_done;
		gap        = 0;
		hold_left  = 0;
		holds_done = 0;
		pop        = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) tracker.check_entry(entry_index, entry_value, last_of_run);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (idling && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 18);
			end
		end
	end

	function automatic logic [IDX_W-1:0] pick_slot(int unsigned n);
		if ($urandom_range(0, 7) == 0) return IDX_W'($urandom);
		return IDX_W'($urandom_range(0, n - 1));
	endfunction

	task automatic offer_event(kind_t k, logic [IDX_W-1:0] p, logic [IDX_W-1:0] t,
			logic [VAL_W-1:0] v);
		push        <= 1'b1;
		kind        <= k;
		peer_id     <= p;
		tuple_index <= t;
		tuple_value <= v;
		do @(posedge clk); while (full);
		tracker.note_event(k, p, t, v);
		if (idling && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// wait for every expected entry, then let any silent event finish inside the block
	task automatic drain();
		push <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(logic [IDX_W-1:0] own_v, logic [CFG_W-1:0] n_v);
		cfg_we    <= 1'b1;
		cfg_index <= REG_OWN_ID;
		cfg_data  <= {1'b0, own_v};
		@(posedge clk);
		tracker.set_reg(REG_OWN_ID, {1'b0, own_v});
		cfg_index <= REG_NUM_PROC;
		cfg_data  <= n_v;
		@(posedge clk);
		tracker.set_reg(REG_NUM_PROC, n_v);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(logic [IDX_W-1:0] own_v, logic [CFG_W-1:0] n_v, int count,
			bit hold, bit calm);
		int               done;
		int               tuples;
		logic [IDX_W-1:0] slot;
		logic [VAL_W-1:0] value;
		done = 0;
		drain();
		write_regs(own_v, n_v);
		idling = !calm;
		if (hold) hold_requests++;
		while (done < count) begin
			if (!calm && $urandom_range(0, 24) == 0) idling = !idling;
			case ($urandom_range(0, 3))
				0: begin
					offer_event(KIND_INTERNAL, IDX_W'($urandom), IDX_W'($urandom), $urandom);
					done++;
				end
				1: begin
					offer_event(KIND_SEND, pick_slot(n_v), IDX_W'($urandom), $urandom);
					done++;
				end
				default: begin
					// incoming message: start marker then its tuples, now and then the marker is lost
					if ($urandom_range(0, 7) != 0) begin
						offer_event(KIND_RECV_START, IDX_W'($urandom), IDX_W'($urandom), $urandom);
						done++;
					end
					tuples = $urandom_range(1, 6);
					repeat (tuples) begin
						slot = pick_slot(n_v);
						case ($urandom_range(0, 2))
							0: value = tracker.clock_vec[slot] + $urandom_range(0, 4) - 2;
							1: value = $urandom_range(0, 300);
							default: value = $urandom;
						endcase
						offer_event(KIND_RECV_TUPLE, IDX_W'($urandom), slot, value);
						done++;
					end
				end
			endcase
		end
	endtask

	initial begin : stimulus
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_OWN_ID;
		cfg_data    = '0;
		push        = 1'b0;
		kind        = KIND_INTERNAL;
		peer_id     = '0;
		tuple_index = '0;
		tuple_value = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(4'd5, 5'd16);
		offer_event(KIND_INTERNAL, 4'd0, 4'd0, 32'd0);
		offer_event(KIND_RECV_START, 4'hF, 4'hF, CLOCK_MAX);
		offer_event(KIND_RECV_TUPLE, 4'd0, 4'd0, 32'd0);
		offer_event(KIND_RECV_TUPLE, 4'd0, 4'hF, CLOCK_MAX);
		offer_event(KIND_RECV_TUPLE, 4'd0, 4'd3, 32'd7);
		offer_event(KIND_SEND, 4'd0, 4'd0, 32'd0);
		offer_event(KIND_SEND, 4'd0, 4'd0, 32'd0);
		offer_event(KIND_SEND, 4'd5, 4'd0, 32'd0);
		offer_event(KIND_SEND, 4'hF, 4'hF, CLOCK_MAX);
		// own entry raised by a tuple close to the top, then bumped into saturation
		offer_event(KIND_RECV_TUPLE, 4'd0, 4'd5, CLOCK_MAX - 2);
		offer_event(KIND_INTERNAL, 4'd0, 4'd0, 32'd0);
		offer_event(KIND_RECV_START, 4'd0, 4'd0, 32'd0);
		offer_event(KIND_INTERNAL, 4'd0, 4'd0, 32'd0);
		offer_event(KIND_SEND, 4'hF, 4'd0, 32'd0);
		// nothing newer than the last stamp for this peer: empty send
		offer_event(KIND_SEND, 4'hF, 4'd0, 32'd0);
		offer_event(KIND_RECV_TUPLE, 4'd0, 4'hF, 32'd5);

		// own index beyond the entries in use
		drain();
		write_regs(4'd5, 5'd4);
		offer_event(KIND_INTERNAL, 4'd0, 4'd0, 32'd0);
		offer_event(KIND_SEND, 4'd0, 4'd0, 32'd0);
		offer_event(KIND_RECV_TUPLE, 4'd0, 4'd1, 32'd9);

		// peer and tuple index beyond the entries in use
		drain();
		write_regs(4'd2, 5'd4);
		offer_event(KIND_SEND, 4'd9, 4'd0, 32'd0);
		offer_event(KIND_RECV_TUPLE, 4'd0, 4'd12, 32'd50);
		offer_event(KIND_RECV_TUPLE, 4'd0, 4'd3, 32'd100);
		offer_event(KIND_SEND, 4'd3, 4'd0, 32'd0);

		run_phase(4'd0, 5'd16, 60, 1'b1, 1'b0);
		run_phase(4'd15, 5'd16, 55, 1'b0, 1'b0);
		run_phase(4'd0, 5'd1, 35, 1'b0, 1'b0);
		run_phase(4'd9, 5'd4, 6, 1'b0, 1'b0);
		run_phase(4'd3, 5'd5, 50, 1'b0, 1'b0);
		run_phase(4'd7, 5'd12, 50, 1'b0, 1'b0);
		run_phase(4'd2, 5'd16, 45, 1'b0, 1'b1);
		drain();

		if (tracker.tally() == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/dvc_pkg.sv
hdl/dvc_front.sv
hdl/dvc_cmd_queue.sv
hdl/dvc_back.sv
hdl/dvc_res_queue.sv
hdl/differential_vector_clock.sv
bench/tb_top.sv
